FILE: rtl/ppa_pkg.sv
// Shared types and constants of the point attractor pipeline.
package ppa_pkg;

    localparam int Q_W        = 32;
    localparam int STR_W      = 21;
    localparam int MAX_W      = 31;
    localparam int MODE_W     = 2;
    localparam int IDX_W      = 3;
    localparam int SQ_W       = 2 * MAX_W;
    localparam int SUM_W      = 64;
    localparam int ROOT_W     = 31;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int REM_W      = ROOT_W + 2;
    localparam int DIR_BITS   = 30;
    localparam int DIV_STEPS  = 32;
    localparam int FDEN_W     = SUM_W + 7;
    localparam int LIN_W      = STR_W + MAX_W;
    localparam int PROD_W     = ROOT_W + DIV_STEPS;

    localparam logic [IDX_W-1:0] REG_POINT_X  = 3'd0;
    localparam logic [IDX_W-1:0] REG_POINT_Y  = 3'd1;
    localparam logic [IDX_W-1:0] REG_POINT_Z  = 3'd2;
    localparam logic [IDX_W-1:0] REG_STRENGTH = 3'd3;
    localparam logic [IDX_W-1:0] REG_FALLOFF  = 3'd4;
    localparam logic [IDX_W-1:0] REG_MAX_DIST = 3'd5;

    localparam logic [MODE_W-1:0] FALL_NONE   = 2'd0;
    localparam logic [MODE_W-1:0] FALL_LINEAR = 2'd1;
    localparam logic [MODE_W-1:0] FALL_INVSQ  = 2'd2;

    typedef struct packed {
        logic signed [Q_W-1:0] pos_x;
        logic signed [Q_W-1:0] pos_y;
        logic signed [Q_W-1:0] pos_z;
        logic signed [Q_W-1:0] vel_in_x;
        logic signed [Q_W-1:0] vel_in_y;
        logic signed [Q_W-1:0] vel_in_z;
    } particle_t;

    typedef struct packed {
        logic signed [Q_W-1:0] vel_out_x;
        logic signed [Q_W-1:0] vel_out_y;
        logic signed [Q_W-1:0] vel_out_z;
        logic                  affected;
    } result_t;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [Q_W-1:0]   wdata;
    } cfg_req_t;

    // Per-particle data carried alongside the distance computation.
    typedef struct packed {
        logic                       hit;
        logic [2:0]                 neg;
        logic [2:0][MAX_W-1:0]      ad;
        logic [2:0][Q_W-1:0]        vel;
        logic [SUM_W-1:0]           sum;
    } ppa_side_t;

    // Per-particle data carried alongside the dividers.
    typedef struct packed {
        logic                       hit;
        logic                       sat;
        logic [2:0]                 neg;
        logic [2:0][Q_W-1:0]        vel;
    } ppa_tail_t;

endpackage

FILE: rtl/ppa_stream_if.sv
// Valid/ready channel interface carrying one payload type.
interface ppa_stream_if #(
    parameter type data_t = logic
) ();
    logic  valid;
    logic  ready;
    data_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/ppa_front.sv
// Offset, range check, squares and squared distance: three pipeline stages.
module ppa_front
    import ppa_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_vld,
    input  particle_t        item,
    input  logic [Q_W-1:0]   point_x,
    input  logic [Q_W-1:0]   point_y,
    input  logic [Q_W-1:0]   point_z,
    input  logic [STR_W-1:0] strength,
    input  logic [MAX_W-1:0] max_dist,
    input  logic [SQ_W-1:0]  max_sq,
    input  logic [SUM_W-1:0] eps_sq,
    output logic             out_vld,
    output ppa_side_t        side
);

    logic                 vld1_reg, vld2_reg, vld3_reg;
    ppa_side_t            s1_reg, s2_reg, s3_reg;
    ppa_side_t            s1_next, s3_next;
    logic [2:0][SQ_W-1:0] sq_reg;

    always_comb
    begin
        logic [2:0][Q_W-1:0] pt;
        logic [2:0][Q_W-1:0] pos;
        logic [2:0][Q_W:0]   diff;
        logic [2:0][Q_W:0]   mag;
        logic [2:0]          inr;
        pt  = {point_z, point_y, point_x};
        pos = {item.pos_z, item.pos_y, item.pos_x};
        s1_next = '0;
        s1_next.vel = {item.vel_in_z, item.vel_in_y, item.vel_in_x};
        for (int i = 0; i < 3; i++)
        begin
            diff[i] = {pt[i][Q_W-1], pt[i]} - {pos[i][Q_W-1], pos[i]};
            mag[i]  = diff[i][Q_W] ? (Q_W+1)'(-diff[i]) : diff[i];
            inr[i]  = mag[i] <= {2'b00, max_dist};
            s1_next.ad[i]  = mag[i][MAX_W-1:0];
            s1_next.neg[i] = diff[i][Q_W] ^ strength[STR_W-1];
        end
        s1_next.hit = (strength != '0) && (&inr);
    end

    always_comb
    begin
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);
        s3_next     = s2_reg;
        s3_next.sum = sum;
        s3_next.hit = s2_reg.hit && (sum <= SUM_W'(max_sq)) && (sum >= eps_sq);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
        end
        else if (en)
        begin
            vld1_reg <= in_vld;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg <= s1_next;
            s2_reg <= s1_reg;
            for (int i = 0; i < 3; i++)
            begin
                sq_reg[i] <= SQ_W'(s1_reg.ad[i]) * SQ_W'(s1_reg.ad[i]);
            end
            s3_reg <= s3_next;
        end
    end

    assign out_vld = vld3_reg;
    assign side    = s3_reg;

endmodule

FILE: rtl/ppa_sqrt.sv
// Integer square root, one result bit per pipeline stage.
module ppa_sqrt
    import ppa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_vld,
    input  ppa_side_t         in_side,
    output logic              out_vld,
    output ppa_side_t         out_side,
    output logic [ROOT_W-1:0] root
);

    logic              vld_reg  [SQRT_STEPS];
    ppa_side_t         side_reg [SQRT_STEPS];
    logic [REM_W-1:0]  rem_reg  [SQRT_STEPS];
    logic [ROOT_W-1:0] root_reg [SQRT_STEPS];

    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_step
        logic              vld_prev;
        ppa_side_t         side_prev;
        logic [REM_W-1:0]  rem_prev;
        logic [ROOT_W-1:0] root_prev;
        logic [REM_W+1:0]  rem_sh;
        logic [REM_W+1:0]  trial;
        logic              ge;

        if (k == 0)
        begin : g_first
            assign vld_prev  = in_vld;
            assign side_prev = in_side;
            assign rem_prev  = '0;
            assign root_prev = '0;
        end
        else
        begin : g_next
            assign vld_prev  = vld_reg[k-1];
            assign side_prev = side_reg[k-1];
            assign rem_prev  = rem_reg[k-1];
            assign root_prev = root_reg[k-1];
        end

        assign rem_sh = {rem_prev, side_prev.sum[2*(SQRT_STEPS-1-k) +: 2]};
        assign trial  = {2'b00, root_prev, 2'b01};
        assign ge     = rem_sh >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= vld_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[k] <= side_prev;
                rem_reg[k]  <= ge ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
                root_reg[k] <= {root_prev[ROOT_W-2:0], ge};
            end
        end
    end

    assign out_vld  = vld_reg[SQRT_STEPS-1];
    assign out_side = side_reg[SQRT_STEPS-1];
    assign root     = root_reg[SQRT_STEPS-1];

endmodule

FILE: rtl/ppa_div.sv
// Restoring divider, one quotient bit per pipeline stage.
module ppa_div
    import ppa_pkg::*;
#(
    parameter int DW = 31
)
(
    input  logic                 clk,
    input  logic                 en,
    input  logic [DW-1:0]        rem_in,
    input  logic [DW-1:0]        den_in,
    input  logic [DIV_STEPS-1:0] lo_in,
    output logic [DIV_STEPS-1:0] quot
);

    logic [DW-1:0]        rem_reg [DIV_STEPS];
    logic [DW-1:0]        den_reg [DIV_STEPS];
    logic [DIV_STEPS-1:0] lo_reg  [DIV_STEPS];
    logic [DIV_STEPS-1:0] q_reg   [DIV_STEPS];

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_step
        logic [DW-1:0]        rem_prev;
        logic [DW-1:0]        den_prev;
        logic [DIV_STEPS-1:0] lo_prev;
        logic [DIV_STEPS-1:0] q_prev;
        logic [DW:0]          rem_sh;
        logic                 ge;

        if (k == 0)
        begin : g_first
            assign rem_prev = rem_in;
            assign den_prev = den_in;
            assign lo_prev  = lo_in;
            assign q_prev   = '0;
        end
        else
        begin : g_next
            assign rem_prev = rem_reg[k-1];
            assign den_prev = den_reg[k-1];
            assign lo_prev  = lo_reg[k-1];
            assign q_prev   = q_reg[k-1];
        end

        assign rem_sh = {rem_prev, lo_prev[DIV_STEPS-1]};
        assign ge     = rem_sh >= {1'b0, den_prev};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= ge ? DW'(rem_sh - {1'b0, den_prev}) : DW'(rem_sh);
                den_reg[k] <= den_prev;
                lo_reg[k]  <= {lo_prev[DIV_STEPS-2:0], 1'b0};
                q_reg[k]   <= {q_prev[DIV_STEPS-2:0], ge};
            end
        end
    end

    assign quot = q_reg[DIV_STEPS-1];

endmodule

FILE: rtl/ppa_back.sv
// Force times direction, then the saturating velocity update: two stages.
module ppa_back
    import ppa_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_vld,
    input  ppa_tail_t                  tail,
    input  logic [DIV_STEPS-1:0]       force_q,
    input  logic [2:0][DIV_STEPS-1:0]  dir,
    output logic                       out_vld,
    output result_t                    res
);

    logic                   vld1_reg, vld2_reg;
    ppa_tail_t              t1_reg;
    logic [2:0][PROD_W-1:0] prod_reg;
    result_t                res_reg, res_next;
    logic [DIV_STEPS-1:0]   g;

    assign g = tail.sat ? '1 : force_q;

    always_comb
    begin
        logic [2:0][Q_W:0]   mag;
        logic [2:0][Q_W+2:0] v;
        logic [2:0][Q_W-1:0] vo;
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = prod_reg[i][PROD_W-1:DIR_BITS];
            if (t1_reg.neg[i])
            begin
                v[i] = {{3{t1_reg.vel[i][Q_W-1]}}, t1_reg.vel[i]} - {2'b00, mag[i]};
            end
            else
            begin
                v[i] = {{3{t1_reg.vel[i][Q_W-1]}}, t1_reg.vel[i]} + {2'b00, mag[i]};
            end
            if (!v[i][Q_W+2] && (v[i][Q_W+1:Q_W-1] != 3'b000))
            begin
                vo[i] = {1'b0, {(Q_W-1){1'b1}}};
            end
            else if (v[i][Q_W+2] && (v[i][Q_W+1:Q_W-1] != 3'b111))
            begin
                vo[i] = {1'b1, {(Q_W-1){1'b0}}};
            end
            else
            begin
                vo[i] = v[i][Q_W-1:0];
            end
            if (!t1_reg.hit)
            begin
                vo[i] = t1_reg.vel[i];
            end
        end
        res_next.vel_out_x = vo[0];
        res_next.vel_out_y = vo[1];
        res_next.vel_out_z = vo[2];
        res_next.affected  = t1_reg.hit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
        end
        else if (en)
        begin
            vld1_reg <= in_vld;
            vld2_reg <= vld1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t1_reg <= tail;
            for (int i = 0; i < 3; i++)
            begin
                prod_reg[i] <= PROD_W'(dir[i][ROOT_W-1:0]) * PROD_W'(g);
            end
            res_reg <= res_next;
        end
    end

    assign out_vld = vld2_reg;
    assign res     = res_reg;

endmodule

FILE: rtl/particle_point_attractor.sv
// Point attractor: one particle per cycle while the pipeline advances; results leave through the output register.
// Throughput is one particle per clock; the whole pipeline moves as one while the
// two-entry output buffer (output register plus skid register) has room.
// Most of the pipeline depth is in the square root (31 stages) and the dividers (32 stages).
// rst_n clears all valid bits and loads the register reset values; no clearing pass.
module particle_point_attractor
    import ppa_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input logic              clk,
    input logic              rst_n,
    ppa_stream_if.sink       particle,
    ppa_stream_if.source     result,
    ppa_stream_if.sink       cfg
);

    // Width of the force division's numerator: the wider of the linear product and
    // the inverse-square dividend |S| * 2^(2F).
    localparam int INV_W = STR_W + 2 * FRAC_BITS;
    localparam int NW    = (INV_W > LIN_W) ? INV_W : LIN_W;

    // Near limit 0.001 in fixed point, rounded, compared in squared form.
    localparam longint unsigned EPS_RAW = ((64'd1 << FRAC_BITS) + 64'd500) / 64'd1000;
    localparam logic [SUM_W-1:0] EPS_SQ = SUM_W'(EPS_RAW * EPS_RAW);

    localparam logic [STR_W-1:0] STRENGTH_RST = 21'd65536;
    localparam logic [MAX_W-1:0] MAX_RST      = 31'd655360;
    localparam logic [SQ_W-1:0]  MAXSQ_RST    = SQ_W'(64'd655360 * 64'd655360);
    localparam logic [MAX_W+6:0] MAXDEN_RST   = (MAX_W+7)'(64'd65536000);

    // ------------------------------------------------------------------
    // Configuration registers. Writes are always taken; the user must do them
    // only while no particle is in flight (not enforced); live reads are then safe.
    // ------------------------------------------------------------------
    logic [Q_W-1:0]    point_x_reg, point_y_reg, point_z_reg;
    logic [STR_W-1:0]  strength_reg;
    logic [MODE_W-1:0] mode_reg;
    logic [MAX_W-1:0]  max_reg;
    logic [SQ_W-1:0]   max_sq_reg;
    logic [MAX_W-1:0]  m_eff_reg;
    logic [MAX_W+6:0]  max_den_reg;
    logic [MAX_W-1:0]  m_eff_next;

    assign cfg.ready = 1'b1;

    // A zero radius is replaced by one in the divisor of the none and linear falloff modes.
    assign m_eff_next = (max_reg == '0) ? MAX_W'(1) : max_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_x_reg  <= '0;
            point_y_reg  <= '0;
            point_z_reg  <= '0;
            strength_reg <= STRENGTH_RST;
            mode_reg     <= FALL_NONE;
            max_reg      <= MAX_RST;
            max_sq_reg   <= MAXSQ_RST;
            m_eff_reg    <= MAX_RST;
            max_den_reg  <= MAXDEN_RST;
        end
        else
        begin
            // Derived values are registered from the radius register, following it in the next cycle.
            max_sq_reg  <= SQ_W'(max_reg) * SQ_W'(max_reg);
            m_eff_reg   <= m_eff_next;
            max_den_reg <= (MAX_W+7)'(m_eff_next) * (MAX_W+7)'(100);
            if (cfg.valid)
            begin
                case (cfg.data.idx)
                    REG_POINT_X:  point_x_reg  <= cfg.data.wdata;
                    REG_POINT_Y:  point_y_reg  <= cfg.data.wdata;
                    REG_POINT_Z:  point_z_reg  <= cfg.data.wdata;
                    REG_STRENGTH: strength_reg <= cfg.data.wdata[STR_W-1:0];
                    REG_FALLOFF:  mode_reg     <= cfg.data.wdata[MODE_W-1:0];
                    REG_MAX_DIST: max_reg      <= cfg.data.wdata[MAX_W-1:0];
                    default:      ;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Pipeline advance. The whole pipeline steps whenever the skid register
    // is empty, so a particle is accepted while a result waits downstream.
    // ------------------------------------------------------------------
    logic en;
    logic skid_vld_reg;

    assign en             = !skid_vld_reg;
    assign particle.ready = en;

    // Stages 1-3: offsets, per-axis range check, squares, squared distance.
    logic      f_vld;
    ppa_side_t f_side;

    ppa_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (particle.valid),
        .item     (particle.data),
        .point_x  (point_x_reg),
        .point_y  (point_y_reg),
        .point_z  (point_z_reg),
        .strength (strength_reg),
        .max_dist (max_reg),
        .max_sq   (max_sq_reg),
        .eps_sq   (EPS_SQ),
        .out_vld  (f_vld),
        .side     (f_side)
    );

    // Stages 4-34: distance as the integer root of the squared distance.
    logic              s_vld;
    ppa_side_t         s_side;
    logic [ROOT_W-1:0] s_root;

    ppa_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (f_vld),
        .in_side  (f_side),
        .out_vld  (s_vld),
        .out_side (s_side),
        .root     (s_root)
    );

    // ------------------------------------------------------------------
    // Stage 35: force dividend and divisor. All falloff modes share one
    // divider: none is |S|*m / (100*m), linear is |S|*(m-d) / (100*m) and
    // inverse square is |S|*2^(2F) / (100*sum), which folds the division
    // by 100 and the quotient cap into one saturating quotient.
    // ------------------------------------------------------------------
    logic              p_vld_reg;
    ppa_side_t         p_side_reg;
    logic [ROOT_W-1:0] p_d_reg;
    logic [NW-1:0]     p_num_reg;
    logic [FDEN_W-1:0] p_den_reg;

    logic [ROOT_W-1:0] d_fix;
    logic [STR_W-1:0]  str_mag;
    logic [MAX_W-1:0]  d_lim;
    logic [MAX_W-1:0]  factor;
    logic [LIN_W-1:0]  lin_prod;
    logic [NW-1:0]     num_next;
    logic [FDEN_W-1:0] den_next;

    always_comb
    begin
        d_fix    = (s_root == '0) ? ROOT_W'(1) : s_root;
        str_mag  = strength_reg[STR_W-1] ? STR_W'(-strength_reg) : strength_reg;
        d_lim    = (d_fix > m_eff_reg) ? m_eff_reg : d_fix;
        factor   = (mode_reg == FALL_LINEAR) ? (m_eff_reg - d_lim) : m_eff_reg;
        lin_prod = LIN_W'(str_mag) * LIN_W'(factor);
        case (mode_reg)
            FALL_INVSQ:
            begin
                num_next = NW'(str_mag) << (2 * FRAC_BITS);
                den_next = FDEN_W'(s_side.sum) * FDEN_W'(100);
            end
            default:
            begin
                num_next = NW'(lin_prod);
                den_next = FDEN_W'(max_den_reg);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            p_vld_reg <= s_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_side_reg <= s_side;
            p_d_reg    <= d_fix;
            p_num_reg  <= num_next;
            p_den_reg  <= den_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 36: divider set-up. The force quotient saturates when its
    // high part already reaches the divisor. The direction quotient is
    // |offset| * 2^30 / d, which never exceeds 2^30 since |offset| <= d.
    // ------------------------------------------------------------------
    logic                     i_vld_reg;
    ppa_tail_t                i_tail_reg;
    logic [FDEN_W-1:0]        i_frem_reg;
    logic [FDEN_W-1:0]        i_fden_reg;
    logic [DIV_STEPS-1:0]     i_flo_reg;
    logic [2:0][ROOT_W-1:0]   i_drem_reg;
    logic [2:0][DIV_STEPS-1:0] i_dlo_reg;
    logic [ROOT_W-1:0]        i_d_reg;

    logic [FDEN_W-1:0] num_hi;
    logic              sat_next;

    assign num_hi   = FDEN_W'(p_num_reg >> DIV_STEPS);
    assign sat_next = num_hi >= p_den_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            i_vld_reg <= p_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            i_tail_reg.hit <= p_side_reg.hit;
            i_tail_reg.sat <= sat_next;
            i_tail_reg.neg <= p_side_reg.neg;
            i_tail_reg.vel <= p_side_reg.vel;
            i_frem_reg     <= sat_next ? '0 : num_hi;
            i_fden_reg     <= p_den_reg;
            i_flo_reg      <= p_num_reg[DIV_STEPS-1:0];
            for (int i = 0; i < 3; i++)
            begin
                i_drem_reg[i] <= {2'b00, p_side_reg.ad[i][MAX_W-1:2]};
                i_dlo_reg[i]  <= {p_side_reg.ad[i][1:0], DIR_BITS'(0)};
            end
            i_d_reg <= p_d_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stages 37-68: four dividers side by side, with the particle's
    // remaining data delayed alongside them.
    // ------------------------------------------------------------------
    logic [DIV_STEPS-1:0]      force_q;
    logic [2:0][DIV_STEPS-1:0] dir_q;

    ppa_div #(.DW(FDEN_W)) u_div_force (
        .clk    (clk),
        .en     (en),
        .rem_in (i_frem_reg),
        .den_in (i_fden_reg),
        .lo_in  (i_flo_reg),
        .quot   (force_q)
    );

    for (genvar a = 0; a < 3; a++)
    begin : g_dir
        ppa_div #(.DW(ROOT_W)) u_div_dir (
            .clk    (clk),
            .en     (en),
            .rem_in (i_drem_reg[a]),
            .den_in (i_d_reg),
            .lo_in  (i_dlo_reg[a]),
            .quot   (dir_q[a])
        );
    end

    logic      dl_vld_reg  [DIV_STEPS];
    ppa_tail_t dl_tail_reg [DIV_STEPS];

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_delay
        logic      vld_prev;
        ppa_tail_t tail_prev;

        if (k == 0)
        begin : g_first
            assign vld_prev  = i_vld_reg;
            assign tail_prev = i_tail_reg;
        end
        else
        begin : g_next
            assign vld_prev  = dl_vld_reg[k-1];
            assign tail_prev = dl_tail_reg[k-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dl_vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                dl_vld_reg[k] <= vld_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dl_tail_reg[k] <= tail_prev;
            end
        end
    end

    // Stages 69-70: velocity change and saturating update.
    logic    b_vld;
    result_t b_res;

    ppa_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (dl_vld_reg[DIV_STEPS-1]),
        .tail    (dl_tail_reg[DIV_STEPS-1]),
        .force_q (force_q),
        .dir     (dir_q),
        .out_vld (b_vld),
        .res     (b_res)
    );

    // ------------------------------------------------------------------
    // Output register with a skid register behind it. When the output is
    // stalled the item leaving the pipeline parks in the skid register,
    // and the pipeline freezes until that register drains.
    // ------------------------------------------------------------------
    logic    out_vld_reg;
    result_t out_data_reg;
    result_t skid_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (out_vld_reg && !result.ready)
        begin
            if (en && b_vld)
            begin
                skid_vld_reg <= 1'b1;
            end
        end
        else if (skid_vld_reg)
        begin
            out_vld_reg  <= 1'b1;
            skid_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= b_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_vld_reg && !result.ready)
        begin
            if (en && b_vld)
            begin
                skid_data_reg <= b_res;
            end
        end
        else if (skid_vld_reg)
        begin
            out_data_reg <= skid_data_reg;
        end
        else
        begin
            out_data_reg <= b_res;
        end
    end

    assign result.valid = out_vld_reg;
    assign result.data  = out_data_reg;

endmodule

FILE: rtl/ppa_checker.sv
// Port-level checks of the point attractor, bound to its top level.
module ppa_checker
    import ppa_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    in_valid,
    input logic    in_ready,
    input logic    out_valid,
    input logic    out_ready,
    input result_t out_data
);

    // A stalled result stays in place unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed or dropped while stalled");

    // Input may only back off after the result side has stalled.
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !(out_valid && !out_ready) |=> in_ready)
        else $error("particle input stalled without a result stall");

    // Reset empties the output side and opens the input.
    a_reset_state: assert property (@(posedge clk)
        !rst_n |-> !out_valid && in_ready)
        else $error("output not empty during reset");

endmodule

bind particle_point_attractor ppa_checker u_ppa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (particle.valid),
    .in_ready  (particle.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_data  (result.data)
);
